// File: hdl/prlb_pkg.sv
// ----------------------------------------------------------------------------
// prlb_pkg: shared types and constants of the per-channel rate limiter
// Field widths, event codes, channel entry and update records, backoff table.
// ----------------------------------------------------------------------------
package prlb_pkg;

    localparam int CHAN_W    = 4;
    localparam int TIME_W    = 32;
    localparam int RETRY_W   = 12;
    localparam int DELAY_W   = 16;
    localparam int WAIT_W    = 22;
    localparam int BACKOFF_W = 12;
    localparam int CNT_W     = 3;
    localparam int EXTRA_W   = 5;
    localparam int TOTAL_W   = 13;
    localparam int GAP_W     = TIME_W + 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;
    localparam logic [WAIT_W-1:0]  MS_PER_S    = 22'd1000;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 3'd7;
    localparam logic [EXTRA_W-1:0] EXTRA_CAP   = 5'd30;

    typedef enum logic [1:0] {
        OP_REQUEST    = 2'd0,
        OP_SUCCESS    = 2'd1,
        OP_RATE_LIMIT = 2'd2
    } t_op;

    // one channel's stored state as read for the current item
    typedef struct packed {
        logic [TIME_W-1:0] last_grant_ms;
        logic              sent_before;
        logic [TIME_W-1:0] cooldown_end_ms;
        logic              cooldown_active;
        logic [CNT_W-1:0]  failure_count;
    } t_entry;

    // state changes caused by the current item
    typedef struct packed {
        logic              grant;
        logic [TIME_W-1:0] grant_ms;
        logic              clr_cooldown;
        logic              set_cooldown;
        logic [TIME_W-1:0] cooldown_end_ms;
        logic              we_count;
        logic [CNT_W-1:0]  count;
    } t_update;

    typedef struct packed {
        logic                 granted;
        logic [WAIT_W-1:0]    wait_ms;
        logic [BACKOFF_W-1:0] backoff_s;
    } t_result;

    // extra backoff seconds: 2^(count-1)-1, capped at 30
    function automatic logic [EXTRA_W-1:0] extra_s(input logic [CNT_W-1:0] cnt);
        logic [EXTRA_W-1:0] e;
        case (cnt)
            3'd2:    e = 5'd1;
            3'd3:    e = 5'd3;
            3'd4:    e = 5'd7;
            3'd5:    e = 5'd15;
            3'd6,
            3'd7:    e = EXTRA_CAP;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// File: hdl/prlb_chan_table.sv
// ----------------------------------------------------------------------------
// prlb_chan_table: per-channel state store
// Flag and count bits reset to zero; time stamps hold garbage until written.
// ----------------------------------------------------------------------------
module prlb_chan_table #(
    parameter int DEPTH = 16,
    parameter int IDXW  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDXW-1:0]      i_idx,
    input  logic                 i_we,
    input  prlb_pkg::t_update    i_upd,
    output prlb_pkg::t_entry     o_entry
);

    logic [prlb_pkg::TIME_W-1:0] r_last_grant [DEPTH];
    logic [prlb_pkg::TIME_W-1:0] r_cd_end     [DEPTH];
    logic                        r_sent       [DEPTH];
    logic                        r_cd_active  [DEPTH];
    logic [prlb_pkg::CNT_W-1:0]  r_fail_cnt   [DEPTH];

    // time stamps: no reset, guarded by the flags
    always_ff @(posedge i_clk) begin
        if (i_we && i_upd.grant) begin
            r_last_grant[i_idx] <= i_upd.grant_ms;
        end
        if (i_we && i_upd.set_cooldown) begin
            r_cd_end[i_idx] <= i_upd.cooldown_end_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_sent[k]      <= 1'b0;
                r_cd_active[k] <= 1'b0;
                r_fail_cnt[k]  <= '0;
            end
        end else if (i_we) begin
            if (i_upd.grant) begin
                r_sent[i_idx] <= 1'b1;
            end
            if (i_upd.set_cooldown) begin
                r_cd_active[i_idx] <= 1'b1;
            end else if (i_upd.clr_cooldown) begin
                r_cd_active[i_idx] <= 1'b0;
            end
            if (i_upd.we_count) begin
                r_fail_cnt[i_idx] <= i_upd.count;
            end
        end
    end

    assign o_entry.last_grant_ms   = r_last_grant[i_idx];
    assign o_entry.sent_before     = r_sent[i_idx];
    assign o_entry.cooldown_end_ms = r_cd_end[i_idx];
    assign o_entry.cooldown_active = r_cd_active[i_idx];
    assign o_entry.failure_count   = r_fail_cnt[i_idx];

endmodule

// File: hdl/prlb_decide.sv
// ----------------------------------------------------------------------------
// prlb_decide: grant / refuse / backoff decision for one event
// Pure combinational; produces the result and the channel state update.
// ----------------------------------------------------------------------------
module prlb_decide (
    input  logic [1:0]                     i_op,
    input  logic                           i_ch_ok,
    input  logic [prlb_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [prlb_pkg::RETRY_W-1:0]   i_retry_after_s,
    input  logic [prlb_pkg::DELAY_W-1:0]   i_min_spacing_ms,
    input  prlb_pkg::t_entry               i_entry,
    output prlb_pkg::t_result              o_res,
    output prlb_pkg::t_update              o_upd
);

    logic [prlb_pkg::TIME_W-1:0]  left;
    logic [prlb_pkg::TIME_W-1:0]  since;
    logic                         in_cooldown;
    logic                         too_soon;
    logic [prlb_pkg::GAP_W-1:0]   gap;
    logic [prlb_pkg::WAIT_W-1:0]  left_sat;
    logic [prlb_pkg::WAIT_W-1:0]  gap_sat;
    logic [prlb_pkg::CNT_W-1:0]   cnt_next;
    logic [prlb_pkg::TOTAL_W-1:0] total_s;
    logic [prlb_pkg::WAIT_W-1:0]  total_ms;
    logic [prlb_pkg::BACKOFF_W-1:0] backoff_sat;

    // cooldown remaining, signed
    assign left        = i_entry.cooldown_end_ms - i_now_ms;
    assign in_cooldown = i_entry.cooldown_active && !left[prlb_pkg::TIME_W-1] && (left != '0);
    assign left_sat    = (|left[prlb_pkg::TIME_W-1:prlb_pkg::WAIT_W]) ? '1
                                                                       : left[prlb_pkg::WAIT_W-1:0];

    // time since last grant, signed; negative counts as too soon
    assign since    = i_now_ms - i_entry.last_grant_ms;
    assign too_soon = since[prlb_pkg::TIME_W-1] ||
                      ((since[prlb_pkg::TIME_W-1:prlb_pkg::DELAY_W] == '0) &&
                       (since[prlb_pkg::DELAY_W-1:0] < i_min_spacing_ms));
    assign gap      = prlb_pkg::GAP_W'(i_min_spacing_ms) -
                      {{2{since[prlb_pkg::TIME_W-1]}}, since};
    assign gap_sat  = (|gap[prlb_pkg::GAP_W-1:prlb_pkg::WAIT_W]) ? '1
                                                                  : gap[prlb_pkg::WAIT_W-1:0];

    // backoff path
    assign cnt_next    = (i_entry.failure_count == prlb_pkg::CNT_MAX) ?
                         i_entry.failure_count : i_entry.failure_count + 3'd1;
    assign total_s     = prlb_pkg::TOTAL_W'(i_retry_after_s) +
                         prlb_pkg::TOTAL_W'(prlb_pkg::extra_s(cnt_next));
    assign total_ms    = prlb_pkg::WAIT_W'(total_s) * prlb_pkg::MS_PER_S;
    assign backoff_sat = total_s[prlb_pkg::TOTAL_W-1] ? '1 : total_s[prlb_pkg::BACKOFF_W-1:0];

    always_comb begin
        o_res                = '0;
        o_upd                = '0;
        o_upd.grant_ms       = i_now_ms;
        o_upd.cooldown_end_ms = i_now_ms + prlb_pkg::TIME_W'(total_ms);
        o_upd.count          = cnt_next;
        if (i_ch_ok) begin
            case (prlb_pkg::t_op'(i_op))
                prlb_pkg::OP_REQUEST: begin
                    if (in_cooldown) begin
                        o_res.wait_ms = left_sat;
                    end else begin
                        o_upd.clr_cooldown = i_entry.cooldown_active;
                        if (i_entry.sent_before && too_soon) begin
                            o_res.wait_ms = gap_sat;
                        end else begin
                            o_res.granted = 1'b1;
                            o_upd.grant   = 1'b1;
                        end
                    end
                end
                prlb_pkg::OP_SUCCESS: begin
                    o_upd.we_count = 1'b1;
                    o_upd.count    = '0;
                end
                prlb_pkg::OP_RATE_LIMIT: begin
                    o_upd.we_count     = 1'b1;
                    o_upd.set_cooldown = 1'b1;
                    o_res.backoff_s    = backoff_sat;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/per_channel_rate_limiter_backoff.sv
// ----------------------------------------------------------------------------
// per_channel_rate_limiter_backoff: per-channel send limiter with backoff
// Grants or refuses send requests per channel, tracks failures and cooldowns.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  in       | i_valid / o_stall    | i_op, i_channel, i_now_ms, i_retry_after_s
//  out      | o_valid / i_stall    | o_granted, o_wait_ms, o_backoff_s
//  config   | i_cfg_we             | i_cfg_wdata (minimum send spacing, ms)
//
//  One item per cycle sustained unless stalled; an item passes the input
//  register, then the result register. The channel entry is read and rewritten
//  while an item moves from the input register to the result register, so the
//  next item always sees the updated entry. Synchronous active-low reset clears
//  flags, failure counts and min delay (1000 ms); no clearing pass is needed.
//  A stall on the output holds the result; one more item fits in the input
//  register before o_stall rises.
//
module per_channel_rate_limiter_backoff #(
    parameter int CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // event input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_op,
    input  logic [prlb_pkg::CHAN_W-1:0]       i_channel,
    input  logic [prlb_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [prlb_pkg::RETRY_W-1:0]      i_retry_after_s,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_granted,
    output logic [prlb_pkg::WAIT_W-1:0]       o_wait_ms,
    output logic [prlb_pkg::BACKOFF_W-1:0]    o_backoff_s,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [prlb_pkg::DELAY_W-1:0]      i_cfg_wdata
);

    // only channels the index field can reach need storage
    localparam int MAX_IDX = 1 << prlb_pkg::CHAN_W;
    localparam int DEPTH   = (CHANNELS < MAX_IDX) ? CHANNELS : MAX_IDX;
    localparam int IDXW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                           r_in_valid, n_in_valid;
    logic [1:0]                     r_op;
    logic [prlb_pkg::CHAN_W-1:0]    r_ch;
    logic [prlb_pkg::TIME_W-1:0]    r_now;
    logic [prlb_pkg::RETRY_W-1:0]   r_retry;

    logic                           r_out_valid, n_out_valid;
    prlb_pkg::t_result              r_res;

    logic [prlb_pkg::DELAY_W-1:0]   r_min_delay;

    logic                           advance;
    logic                           load_in;
    logic                           fire;
    logic                           ch_ok;
    prlb_pkg::t_entry               entry;
    prlb_pkg::t_result              res;
    prlb_pkg::t_update              upd;

    // result register can take a new item when empty or being drained
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign load_in = i_valid && !o_stall;
    assign fire    = r_in_valid && advance;
    assign ch_ok   = (32'(r_ch) < CHANNELS);

    assign n_in_valid  = load_in || (r_in_valid && !advance);
    assign n_out_valid = fire || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_min_delay <= prlb_pkg::DELAY_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_min_delay <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_op    <= i_op;
            r_ch    <= i_channel;
            r_now   <= i_now_ms;
            r_retry <= i_retry_after_s;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    prlb_chan_table #(
        .DEPTH (DEPTH),
        .IDXW  (IDXW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_ch[IDXW-1:0]),
        .i_we    (fire),
        .i_upd   (upd),
        .o_entry (entry)
    );

    prlb_decide u_decide (
        .i_op             (r_op),
        .i_ch_ok          (ch_ok),
        .i_now_ms         (r_now),
        .i_retry_after_s  (r_retry),
        .i_min_spacing_ms (r_min_delay),
        .i_entry          (entry),
        .o_res            (res),
        .o_upd            (upd)
    );

    assign o_valid     = r_out_valid;
    assign o_granted   = r_res.granted;
    assign o_wait_ms   = r_res.wait_ms;
    assign o_backoff_s = r_res.backoff_s;

endmodule

// File: hdl/prlb_checker.sv
// ----------------------------------------------------------------------------
// prlb_checker: port-level checks for the rate limiter
// Bound to the top level; watches handshakes and result consistency.
// ----------------------------------------------------------------------------
module prlb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic                           o_stall,
    input  logic                           o_granted,
    input  logic [prlb_pkg::WAIT_W-1:0]    o_wait_ms,
    input  logic [prlb_pkg::BACKOFF_W-1:0] o_backoff_s
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // input side only backs up when a result is waiting and stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room downstream");

    // a grant carries no wait and no backoff
    a_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_granted |-> (o_wait_ms == '0) && (o_backoff_s == '0))
        else $error("grant with wait or backoff");

    // a refusal wait and a backoff never come from the same event
    a_wait_xor_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wait_ms == '0) || (o_backoff_s == '0))
        else $error("wait and backoff both set");

endmodule

bind per_channel_rate_limiter_backoff prlb_checker u_prlb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_granted   (o_granted),
    .o_wait_ms   (o_wait_ms),
    .o_backoff_s (o_backoff_s)
);
